// ===== design/rle_sprite_pixel_decoder_macros.svh =====
// Assertion macros shared by the sprite decoder modules.
`ifndef RLE_SPRITE_PIXEL_DECODER_MACROS_SVH
`define RLE_SPRITE_PIXEL_DECODER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define RSPD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rspd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RSPD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rspd assertion failed");

`endif

// ===== design/rspd_pkg.sv =====
package rspd_pkg;

   localparam int CoordBits = 16;

   localparam logic [7:0] CodeEnd = 8'hFF;
   localparam logic [7:0] CodeRow = 8'hFE;
   localparam logic [7:0] PixFont = 8'h01;
   localparam logic [7:0] PixShadow = 8'h07;

   typedef logic [CoordBits-1:0] coord_type;

   typedef enum logic [1:0] {
      PH_CODE   = 2'd0,
      PH_COUNT  = 2'd1,
      PH_PIXELS = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X     = 3'd0,
      REG_ORIGIN_Y     = 3'd1,
      REG_PROBE_X      = 3'd2,
      REG_PROBE_Y      = 3'd3,
      REG_GLYPH_MODE   = 3'd4,
      REG_FONT_COLOR   = 3'd5,
      REG_SHADOW_COLOR = 3'd6
   } reg_index_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_END   = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] probe_x;
      logic signed [15:0] probe_y;
      logic               glyph_mode;
      logic [7:0]         font_color;
      logic [7:0]         shadow_color;
   } cfg_type;

   typedef struct packed {
      item_kind_type      item_kind;
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic [7:0]         pixel_color;
      logic               probe_hit;
   } result_type;

   // Sign-extends or truncates a 16-bit register value to the coordinate width.
   function automatic coord_type to_coord(logic signed [15:0] v);
      return coord_type'(v);
   endfunction

   // Takes the low 16 bits of a coordinate, zero-extending a narrower one.
   function automatic logic signed [15:0] to_screen(coord_type c);
      return 16'(c);
   endfunction

endpackage

// ===== design/rspd_decode.sv =====
module rspd_decode
   import rspd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

`include "rle_sprite_pixel_decoder_macros.svh"

   phase_type phase_ff, phase_in;
   coord_type col_ff, col_in;
   coord_type row_ff, row_in;
   logic [7:0] left_ff, left_in;
   logic hit_ff, hit_in;

   coord_type px;
   coord_type py;
   logic probe_match;
   logic [7:0] color;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CODE;
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         hit_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         col_ff <= col_in;
         row_ff <= row_in;
         left_ff <= left_in;
         hit_ff <= hit_in;
      end
   end

   always_comb begin
      px = to_coord(cfg.origin_x) + col_ff;
      py = to_coord(cfg.origin_y) + row_ff;
      probe_match = (px == to_coord(cfg.probe_x)) && (py == to_coord(cfg.probe_y));
      color = data_byte;
      if (cfg.glyph_mode) begin
         if (data_byte == PixFont) begin
            color = cfg.font_color;
         end else if (data_byte == PixShadow) begin
            color = cfg.shadow_color;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      col_in = col_ff;
      row_in = row_ff;
      left_in = left_ff;
      hit_in = hit_ff;
      res_valid = 1'b0;
      res.item_kind = KIND_PIXEL;
      res.pixel_x = '0;
      res.pixel_y = '0;
      res.pixel_color = '0;
      res.probe_hit = hit_ff;
      case (phase_ff)
         PH_COUNT: begin
            left_in = data_byte;
            phase_in = (data_byte != 8'd0) ? PH_PIXELS : PH_CODE;
         end
         PH_PIXELS: begin
            hit_in = hit_ff | probe_match;
            res_valid = 1'b1;
            res.pixel_x = to_screen(px);
            res.pixel_y = to_screen(py);
            res.pixel_color = color;
            res.probe_hit = hit_ff | probe_match;
            col_in = col_ff + coord_type'(1);
            left_in = left_ff - 8'd1;
            if (left_in == 8'd0) begin
               phase_in = PH_CODE;
            end
         end
         default: begin
            if (data_byte == CodeEnd) begin
               res_valid = 1'b1;
               res.item_kind = KIND_END;
               phase_in = PH_CODE;
               col_in = '0;
               row_in = '0;
               left_in = '0;
               hit_in = 1'b0;
            end else if (data_byte == CodeRow) begin
               col_in = '0;
               row_in = row_ff + coord_type'(1);
               phase_in = PH_CODE;
            end else begin
               col_in = col_ff + coord_type'(data_byte);
               phase_in = PH_COUNT;
            end
         end
      endcase
   end

   `RSPD_ASSERT_SAME(a_pixels_pending, phase_ff == PH_PIXELS, left_ff != 8'd0)
   `RSPD_ASSERT_NEXT(a_end_restarts, fire && res_valid && res.item_kind == KIND_END, phase_ff == PH_CODE && col_ff == '0 && row_ff == '0 && !hit_ff)
   `RSPD_ASSERT_SAME(a_end_zero_fields, res_valid && res.item_kind == KIND_END, res.pixel_x == '0 && res.pixel_y == '0 && res.pixel_color == '0)

endmodule

// ===== design/rle_sprite_pixel_decoder.sv =====
// Bytes are accepted into the input register and decoded there; pixel and end
// results go to the result register. Throughput: one byte per cycle unless a
// full, stalled result register blocks it, set by the single decode stage.
// Reset is synchronous and active high; it restores all configuration
// registers and the decode state to their defaults and empties both registers.
module rle_sprite_pixel_decoder
   import rspd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_item_kind,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [7:0]         rsp_pixel_color,
   output logic               rsp_probe_hit,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

`include "rle_sprite_pixel_decoder_macros.svh"

   cfg_type cfg_ff;
   logic in_valid_ff;
   logic [7:0] in_byte_ff;
   logic out_valid_ff, out_valid_in;
   result_type out_ff;

   logic out_free;
   logic advance;
   logic res_valid;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.probe_x <= -16'sd1;
         cfg_ff.probe_y <= -16'sd1;
         cfg_ff.glyph_mode <= 1'b0;
         cfg_ff.font_color <= 8'd1;
         cfg_ff.shadow_color <= 8'd7;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_ORIGIN_X: cfg_ff.origin_x <= csr_data;
            REG_ORIGIN_Y: cfg_ff.origin_y <= csr_data;
            REG_PROBE_X: cfg_ff.probe_x <= csr_data;
            REG_PROBE_Y: cfg_ff.probe_y <= csr_data;
            REG_GLYPH_MODE: cfg_ff.glyph_mode <= csr_data[0];
            REG_FONT_COLOR: cfg_ff.font_color <= csr_data[7:0];
            REG_SHADOW_COLOR: cfg_ff.shadow_color <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign out_valid_in = out_free ? (advance && res_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   rspd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .data_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item_kind = out_ff.item_kind;
   assign rsp_pixel_x = out_ff.pixel_x;
   assign rsp_pixel_y = out_ff.pixel_y;
   assign rsp_pixel_color = out_ff.pixel_color;
   assign rsp_probe_hit = out_ff.probe_hit;

   `RSPD_ASSERT_NEXT(a_held_byte_kept, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))
   `RSPD_ASSERT_NEXT(a_held_result_kept, out_valid_ff && rsp_stall, out_valid_ff && $stable(out_ff))
   `RSPD_ASSERT_SAME(a_stall_only_when_full, req_stall, in_valid_ff && out_valid_ff && rsp_stall)

endmodule

// ===== tb/rle_sprite_pixel_decoder_checker.sv =====
module rle_sprite_pixel_decoder_checker
   import rspd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_item_kind,
   input  logic signed [15:0] rsp_pixel_x,
   input  logic signed [15:0] rsp_pixel_y,
   input  logic [7:0]         rsp_pixel_color,
   input  logic               rsp_probe_hit,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 mismatch_count,
   output int                 pending_count
);

   cfg_type    settings;
   phase_type  decode_phase;
   coord_type  column_offset;
   coord_type  row_offset;
   logic [7:0] pixels_left;
   logic       hit_seen;
   result_type predicted_items[$];
   result_type oldest;

   task automatic restart_image();
      decode_phase = PH_CODE;
      column_offset = '0;
      row_offset = '0;
      pixels_left = '0;
      hit_seen = 1'b0;
   endtask

   task automatic decode_byte(input logic [7:0] b);
      result_type item;
      coord_type  px;
      coord_type  py;
      logic [7:0] color;
      case (decode_phase)
         PH_COUNT: begin
            pixels_left = b;
            decode_phase = (b != 8'd0) ? PH_PIXELS : PH_CODE;
         end
         PH_PIXELS: begin
            px = coord_type'(settings.origin_x) + column_offset;
            py = coord_type'(settings.origin_y) + row_offset;
            color = b;
            if (settings.glyph_mode) begin
               if (b == PixFont) color = settings.font_color;
               else if (b == PixShadow) color = settings.shadow_color;
            end
            if (px == coord_type'(settings.probe_x) && py == coord_type'(settings.probe_y))
               hit_seen = 1'b1;
            item.item_kind = KIND_PIXEL;
            item.pixel_x = px;
            item.pixel_y = py;
            item.pixel_color = color;
            item.probe_hit = hit_seen;
            predicted_items.push_back(item);
            column_offset = column_offset + coord_type'(1);
            pixels_left = pixels_left - 8'd1;
            if (pixels_left == 8'd0) decode_phase = PH_CODE;
         end
         default: begin
            if (b == CodeEnd) begin
               item.item_kind = KIND_END;
               item.pixel_x = '0;
               item.pixel_y = '0;
               item.pixel_color = '0;
               item.probe_hit = hit_seen;
               predicted_items.push_back(item);
               restart_image();
            end else if (b == CodeRow) begin
               column_offset = '0;
               row_offset = row_offset + coord_type'(1);
               decode_phase = PH_CODE;
            end else begin
               column_offset = column_offset + coord_type'(b);
               decode_phase = PH_COUNT;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.origin_x = '0;
         settings.origin_y = '0;
         settings.probe_x = 16'shFFFF;
         settings.probe_y = 16'shFFFF;
         settings.glyph_mode = 1'b0;
         settings.font_color = 8'd1;
         settings.shadow_color = 8'd7;
         restart_image();
         predicted_items.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_items.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected result transaction: kind %0d x %0d y %0d color %0d hit %0d",
                           rsp_item_kind, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                           rsp_probe_hit);
            end else begin
               oldest = predicted_items.pop_front();
               if (oldest.item_kind !== rsp_item_kind || oldest.pixel_x !== rsp_pixel_x ||
                   oldest.pixel_y !== rsp_pixel_y || oldest.pixel_color !== rsp_pixel_color ||
                   oldest.probe_hit !== rsp_probe_hit) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $write("result mismatch: expected kind %0d x %0d y %0d color %0d hit %0d,",
                            oldest.item_kind, oldest.pixel_x, oldest.pixel_y,
                            oldest.pixel_color, oldest.probe_hit);
                     $display(" got kind %0d x %0d y %0d color %0d hit %0d",
                              rsp_item_kind, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                              rsp_probe_hit);
                  end
               end
            end
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte);
         if (csr_write) begin
            case (csr_index)
               REG_ORIGIN_X:     settings.origin_x = csr_data;
               REG_ORIGIN_Y:     settings.origin_y = csr_data;
               REG_PROBE_X:      settings.probe_x = csr_data;
               REG_PROBE_Y:      settings.probe_y = csr_data;
               REG_GLYPH_MODE:   settings.glyph_mode = csr_data[0];
               REG_FONT_COLOR:   settings.font_color = csr_data[7:0];
               REG_SHADOW_COLOR: settings.shadow_color = csr_data[7:0];
               default: ;
            endcase
         end
      end
      pending_count <= predicted_items.size();
   end

endmodule

// ===== tb/rle_sprite_pixel_decoder_test.sv =====
module rle_sprite_pixel_decoder_test
   import rspd_pkg::*;
();

   localparam int CycleLimit = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_item_kind;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic [7:0]         rsp_pixel_color;
   logic               rsp_probe_hit;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   int mismatch_count;
   int pending_count;
   int send_idle = 0;
   int recv_idle = 0;
   int bytes_sent = 0;
   int cycle_count = 0;

   rle_sprite_pixel_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_probe_hit   (rsp_probe_hit),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   rle_sprite_pixel_decoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_probe_hit   (rsp_probe_hit),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic put_byte(input logic [7:0] value);
      logic taken;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type index, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input cfg_type c);
      write_reg(REG_ORIGIN_X, c.origin_x);
      write_reg(REG_ORIGIN_Y, c.origin_y);
      write_reg(REG_PROBE_X, c.probe_x);
      write_reg(REG_PROBE_Y, c.probe_y);
      write_reg(REG_GLYPH_MODE, {15'($urandom), c.glyph_mode});
      write_reg(REG_FONT_COLOR, {8'($urandom), c.font_color});
      write_reg(REG_SHADOW_COLOR, {8'($urandom), c.shadow_color});
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] pick_coordinate();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      cfg_type    setting;
      logic [7:0] first_image[12];
      logic [7:0] second_image[6];
      int         rows;
      int         runs;
      int         count;
      int         start;
      int         n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle = 28;
      recv_idle <= 57;

      // Column wrap, row wrap, probe hit, glyph remap and a zero count.
      setting = '{origin_x: 16'sh7FFF, origin_y: 16'shFFFF, probe_x: 16'sh8000,
                  probe_y: 16'shFFFF, glyph_mode: 1'b1, font_color: 8'hAA,
                  shadow_color: 8'h55};
      set_config(setting);
      first_image = '{8'h00, 8'h03, PixFont, PixShadow, CodeEnd, CodeRow,
                      8'hFD, 8'h00, 8'h00, 8'h01, 8'h80, CodeEnd};
      foreach (first_image[i]) put_byte(first_image[i]);
      drain();

      // Plain mode passes the glyph values through; an empty image follows an end.
      setting = '{origin_x: 16'sh8000, origin_y: 16'sh7FFF, probe_x: 16'sh0000,
                  probe_y: 16'sh0000, glyph_mode: 1'b0, font_color: 8'hFF,
                  shadow_color: 8'h00};
      set_config(setting);
      second_image = '{8'h00, 8'h02, PixFont, PixShadow, CodeEnd, CodeEnd};
      foreach (second_image[i]) put_byte(second_image[i]);

      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 28 : (p == 1) ? 57 : 0;
         recv_idle <= (p == 0) ? 57 : (p == 1) ? 28 : 0;
         for (int s = 0; s < 3; s++) begin
            drain();
            setting.origin_x = pick_coordinate();
            setting.origin_y = pick_coordinate();
            if ($urandom_range(4) == 0) begin
               setting.probe_x = 16'($urandom);
               setting.probe_y = 16'($urandom);
            end else begin
               setting.probe_x = setting.origin_x + 16'($urandom_range(0, 6));
               setting.probe_y = setting.origin_y + 16'($urandom_range(0, 3));
            end
            setting.glyph_mode = 1'($urandom_range(1));
            setting.font_color = 8'($urandom);
            setting.shadow_color = 8'($urandom);
            set_config(setting);
            start = bytes_sent;
            while (bytes_sent - start < 80) begin
               if ($urandom_range(9) == 0) begin
                  n = $urandom_range(1, 10);
                  repeat (n) put_byte(8'($urandom));
               end else begin
                  rows = $urandom_range(1, 4);
                  for (int r = 0; r < rows; r++) begin
                     runs = $urandom_range(0, 3);
                     repeat (runs) begin
                        put_byte(($urandom_range(7) == 0) ? 8'($urandom_range(0, 253))
                                                           : 8'($urandom_range(0, 4)));
                        count = ($urandom_range(49) == 0) ? $urandom_range(200, 255)
                                                          : $urandom_range(0, 8);
                        put_byte(8'(count));
                        repeat (count) begin
                           case ($urandom_range(5))
                              0: put_byte(PixFont);
                              1: put_byte(PixShadow);
                              2: put_byte(CodeEnd);
                              3: put_byte(CodeRow);
                              default: put_byte(8'($urandom));
                           endcase
                        end
                     end
                     if (r < rows - 1) put_byte(CodeRow);
                  end
                  put_byte(CodeEnd);
               end
            end
         end
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
